// ===== hdl/sacr_pkg.sv =====
// sacr_pkg: shared types, codes and helpers for the cache replacement block
// no dependencies; compiled first

package sacr_pkg;

    // fixed field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int POL_W      = 2;
    localparam int OFF_W      = 5;
    localparam int SETS_CFG_W = 4;
    localparam int WAYS_CFG_W = 2;
    localparam int WAY_OUT_W  = 3;
    localparam int CNT_W      = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_SETS   = 2'd2,
        CFG_WAYS   = 2'd3
    } t_cfg_idx;

    // replacement policy codes, code 3 behaves as lru
    localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
    localparam logic [POL_W-1:0] POL_NRU  = 2'd2;

    localparam logic CMD_WRITE = 1'b1;

    // register reset values
    localparam logic [POL_W-1:0]      POLICY_RESET = POL_LRU;
    localparam logic [OFF_W-1:0]      OFFSET_RESET = 5'd6;
    localparam logic [SETS_CFG_W-1:0] SETS_RESET   = 4'd0;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET   = 2'd0;

    // status of one set scan
    typedef struct packed {
        logic hit;
        logic free_found;
        logic nru_found;
    } t_scan_flags;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== hdl/sacr_if.sv =====
// sacr_if: request, result and configuration channels of the cache block
// depends on sacr_pkg

interface sacr_req_if #(parameter int ADDRESS_BITS = 48) ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [ADDRESS_BITS-1:0] address;

    modport source (output valid, command, address, input ready);
    modport sink   (input valid, command, address, output ready);
endinterface

interface sacr_rsp_if
    import sacr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 memory_read;
    logic                 memory_write;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     read_count;
    logic [CNT_W-1:0]     write_count;

    modport source (output valid, hit, way_used, memory_read, memory_write,
                    hit_count, miss_count, read_count, write_count, input ready);
    modport sink   (input valid, hit, way_used, memory_read, memory_write,
                    hit_count, miss_count, read_count, write_count, output ready);
endinterface

interface sacr_cfg_if
    import sacr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/set_assoc_cache_replacement.sv =====
// set_assoc_cache_replacement: set-associative cache tag model, top level
// depends on sacr_pkg, sacr_if, sacr_ram, sacr_scan

// Write-through, write-allocate tag model with fifo, lru or nru replacement.
// Each request splits its address into offset, set and tag, then walks the
// ways of the set one per cycle through a single tag/stamp compare unit,
// reading tags and metadata from two rams. When nru finds no flag set in a
// full set that is not direct mapped, an extra pass marks the set before the
// update; the way walk over the ram read port sets the length of a request.
// After reset a clearing pass over all MAX_SETS*MAX_WAYS entries (rounded up
// to powers of two) zeroes the valid bits and stamps; no request is taken
// during it, configuration writes are. One result goes out per request and
// sits in an output register, so the next request may be taken while the
// result still waits. The four counters saturate at all ones. Change
// configuration only while idle.

module set_assoc_cache_replacement
    import sacr_pkg::*;
#(
    parameter int MAX_SETS     = 256,
    parameter int MAX_WAYS     = 8,
    parameter int ADDRESS_BITS = 48,
    parameter int STAMP_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacr_req_if.sink    i_req,
    sacr_cfg_if.sink    i_cfg,
    sacr_rsp_if.source  o_rsp
);

    // geometry derived from the size limits
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENT_W  = SET_W + WAY_W;
    localparam int DEPTH  = 1 << ENT_W;
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WB_MAX = $clog2(MAX_WAYS + 1) - 1;
    localparam int META_W = STAMP_BITS + 1;
    localparam int SH_W   = 6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_NRU,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [POL_W-1:0]      r_policy;
    logic [OFF_W-1:0]      r_offset;
    logic [SETS_CFG_W-1:0] r_set_bits;
    logic [WAYS_CFG_W-1:0] r_way_bits;

    // request being worked on
    logic                    r_cmd;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [SET_W-1:0]        r_set;
    logic [ADDRESS_BITS-1:0] r_tag;
    logic [WAY_W:0]          r_nways;
    logic [WAY_W:0]          r_iss;
    logic                    r_cmp_vld;
    logic [WAY_W-1:0]        r_cmp_way;
    logic [WAY_W-1:0]        r_used;
    logic                    r_hit;

    // clear pass address
    logic [ENT_W-1:0] r_clr;

    // global state
    logic [STAMP_BITS-1:0] r_clock;
    logic [CNT_W-1:0]      r_hits;
    logic [CNT_W-1:0]      r_misses;
    logic [CNT_W-1:0]      r_reads;
    logic [CNT_W-1:0]      r_writes;

    // output register
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic [WAY_OUT_W-1:0] r_out_way;
    logic                 r_out_mrd;
    logic                 r_out_mwr;
    logic [CNT_W-1:0]     r_out_hits;
    logic [CNT_W-1:0]     r_out_misses;
    logic [CNT_W-1:0]     r_out_reads;
    logic [CNT_W-1:0]     r_out_writes;

    // address split, clamped geometry
    logic [SETS_CFG_W-1:0]   sb;
    logic [WAYS_CFG_W-1:0]   wb;
    logic [SET_W:0]          set_mask_w;
    logic [ADDRESS_BITS-1:0] addr_sh;
    logic [SH_W-1:0]         tag_shift;

    // ram ports
    logic                    meta_we;
    logic [ENT_W-1:0]        meta_waddr;
    logic [META_W-1:0]       meta_wdata;
    logic [META_W-1:0]       meta_rdata;
    logic                    tag_we;
    logic [ENT_W-1:0]        tag_waddr;
    logic [ADDRESS_BITS-1:0] tag_rdata;
    logic [ENT_W-1:0]        rd_addr;

    // scan results
    t_scan_flags      flags;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] nru_way;
    logic [WAY_W-1:0] vic_way;
    logic [WAY_W-1:0] used;
    logic             nru_all;
    logic             out_load;

    // clamp set and way counts to what the rams hold
    assign sb = (int'(r_set_bits) > SB_MAX) ? SETS_CFG_W'(SB_MAX) : r_set_bits;
    assign wb = (int'(r_way_bits) > WB_MAX) ? WAYS_CFG_W'(WB_MAX) : r_way_bits;

    assign set_mask_w = ((SET_W + 1)'(1) << sb) - (SET_W + 1)'(1);
    assign addr_sh    = r_addr >> r_offset;
    assign tag_shift  = SH_W'(r_offset) + SH_W'(sb);

    // way walk reads set entries in order
    assign rd_addr = {r_set, r_iss[WAY_W-1:0]};

    // victim choice once the scan has finished
    always_comb begin
        if (flags.hit) begin
            used = hit_way;
        end else if (flags.free_found) begin
            used = free_way;
        end else if (r_policy == POL_NRU) begin
            used = flags.nru_found ? nru_way : '0;
        end else begin
            used = vic_way;
        end
    end

    // nru with no flag set in a full set of more than one way: mark the other ways, replace way 0
    assign nru_all = !flags.hit && !flags.free_found && (r_policy == POL_NRU)
                   && !flags.nru_found && (r_nways != (WAY_W + 1)'(1));

    // ram write control
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = rd_addr;
        meta_wdata = {1'b1, STAMP_BITS'(1)};
        tag_we     = 1'b0;
        tag_waddr  = {r_set, used};
        case (r_state)
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = '0;
            end
            S_NRU: begin
                meta_we = 1'b1;
            end
            S_UPDATE: begin
                // fifo hit leaves the insert stamp alone
                meta_we    = !(flags.hit && (r_policy == POL_FIFO));
                meta_waddr = {r_set, used};
                meta_wdata = {1'b1, (r_policy == POL_NRU) ? {STAMP_BITS{1'b0}} : r_clock};
                tag_we     = !flags.hit;
            end
            default: begin
            end
        endcase
    end

    sacr_ram #(
        .WIDTH (META_W),
        .DEPTH (DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (rd_addr),
        .o_rdata (meta_rdata)
    );

    sacr_ram #(
        .WIDTH (ADDRESS_BITS),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_tag),
        .i_raddr (rd_addr),
        .o_rdata (tag_rdata)
    );

    // shared compare unit, one way per cycle
    sacr_scan #(
        .WAY_W        (WAY_W),
        .ADDRESS_BITS (ADDRESS_BITS),
        .STAMP_BITS   (STAMP_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_PREP),
        .i_en       (r_cmp_vld),
        .i_way      (r_cmp_way),
        .i_valid    (meta_rdata[META_W-1]),
        .i_stamp    (meta_rdata[STAMP_BITS-1:0]),
        .i_tag_rd   (tag_rdata),
        .i_tag      (r_tag),
        .o_flags    (flags),
        .o_hit_way  (hit_way),
        .o_free_way (free_way),
        .o_nru_way  (nru_way),
        .o_vic_way  (vic_way)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // sequencer, configuration, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_policy   <= POLICY_RESET;
            r_offset   <= OFFSET_RESET;
            r_set_bits <= SETS_RESET;
            r_way_bits <= WAYS_RESET;
            r_clock    <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_reads    <= '0;
            r_writes   <= '0;
            r_out_vld  <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_iss      <= '0;
        end else begin
            // configuration writes are always taken
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_POLICY: r_policy   <= i_cfg.data[POL_W-1:0];
                    CFG_OFFSET: r_offset   <= i_cfg.data[OFF_W-1:0];
                    CFG_SETS:   r_set_bits <= i_cfg.data[SETS_CFG_W-1:0];
                    CFG_WAYS:   r_way_bits <= i_cfg.data[WAYS_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ENT_W'(1);
                    if (r_clr == {ENT_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd   <= i_req.command;
                        r_addr  <= i_req.address;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // split the address, size the way walk
                    r_set     <= addr_sh[SET_W-1:0] & set_mask_w[SET_W-1:0];
                    r_tag     <= r_addr >> tag_shift;
                    r_nways   <= (WAY_W + 1)'(1) << wb;
                    r_iss     <= '0;
                    r_cmp_vld <= 1'b0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    // issue one read a cycle, compare it the cycle after
                    if (r_iss != r_nways) begin
                        r_iss     <= r_iss + (WAY_W + 1)'(1);
                        r_cmp_vld <= 1'b1;
                        r_cmp_way <= r_iss[WAY_W-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                        if (!r_cmp_vld) begin
                            if (nru_all) begin
                                r_iss   <= (WAY_W + 1)'(1);
                                r_state <= S_NRU;
                            end else begin
                                r_state <= S_UPDATE;
                            end
                        end
                    end
                end
                S_NRU: begin
                    // set the flag of ways 1 and up, way 0 is refilled next
                    r_iss <= r_iss + (WAY_W + 1)'(1);
                    if (r_iss == r_nways - (WAY_W + 1)'(1)) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_used  <= used;
                    r_hit   <= flags.hit;
                    r_clock <= r_clock + STAMP_BITS'(1);
                    if (flags.hit) begin
                        r_hits <= sat_inc(r_hits);
                    end else begin
                        r_misses <= sat_inc(r_misses);
                        r_reads  <= sat_inc(r_reads);
                    end
                    if (r_cmd == CMD_WRITE) begin
                        r_writes <= sat_inc(r_writes);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // wait for room in the output register
                    if (out_load) begin
                        r_out_hit    <= r_hit;
                        r_out_way    <= WAY_OUT_W'(r_used);
                        r_out_mrd    <= !r_hit;
                        r_out_mwr    <= (r_cmd == CMD_WRITE);
                        r_out_hits   <= r_hits;
                        r_out_misses <= r_misses;
                        r_out_reads  <= r_reads;
                        r_out_writes <= r_writes;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.way_used     = r_out_way;
    assign o_rsp.memory_read  = r_out_mrd;
    assign o_rsp.memory_write = r_out_mwr;
    assign o_rsp.hit_count    = r_out_hits;
    assign o_rsp.miss_count   = r_out_misses;
    assign o_rsp.read_count   = r_out_reads;
    assign o_rsp.write_count  = r_out_writes;

endmodule

// ===== hdl/sacr_ram.sv =====
// sacr_ram: generic single write port, single read port ram, registered read
// no dependencies

module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sacr_scan.sv =====
// sacr_scan: per-way tag compare and victim tracking, one way per cycle
// depends on sacr_pkg

module sacr_scan
    import sacr_pkg::*;
#(
    parameter int WAY_W        = 3,
    parameter int ADDRESS_BITS = 48,
    parameter int STAMP_BITS   = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_en,
    input  logic [WAY_W-1:0]        i_way,
    input  logic                    i_valid,
    input  logic [STAMP_BITS-1:0]   i_stamp,
    input  logic [ADDRESS_BITS-1:0] i_tag_rd,
    input  logic [ADDRESS_BITS-1:0] i_tag,
    output t_scan_flags             o_flags,
    output logic [WAY_W-1:0]        o_hit_way,
    output logic [WAY_W-1:0]        o_free_way,
    output logic [WAY_W-1:0]        o_nru_way,
    output logic [WAY_W-1:0]        o_vic_way
);

    t_scan_flags           r_flags;
    logic [WAY_W-1:0]      r_hit_way;
    logic [WAY_W-1:0]      r_free_way;
    logic [WAY_W-1:0]      r_nru_way;
    logic [WAY_W-1:0]      r_vic_way;
    logic [STAMP_BITS-1:0] r_min;
    logic                  match;

    assign match = i_valid && (i_tag_rd == i_tag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else if (i_en) begin
            // first valid way with the tag
            if (!r_flags.hit && match) begin
                r_flags.hit <= 1'b1;
                r_hit_way   <= i_way;
            end
            // first invalid way
            if (!r_flags.free_found && !i_valid) begin
                r_flags.free_found <= 1'b1;
                r_free_way         <= i_way;
            end
            // first way with its not-recent flag set
            if (!r_flags.nru_found && (i_stamp != '0)) begin
                r_flags.nru_found <= 1'b1;
                r_nru_way         <= i_way;
            end
            // oldest stamp, lowest way on ties
            if ((i_way == '0) || (i_stamp < r_min)) begin
                r_min     <= i_stamp;
                r_vic_way <= i_way;
            end
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_way  = r_hit_way;
    assign o_free_way = r_free_way;
    assign o_nru_way  = r_nru_way;
    assign o_vic_way  = r_vic_way;

endmodule

// ===== hdl/sacr_chk.sv =====
// sacr_chk: port-level checks for the cache replacement block, bound to the top
// depends on sacr_pkg and set_assoc_cache_replacement

module sacr_chk
    import sacr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic             i_hit,
    input logic             i_memory_read,
    input logic [CNT_W-1:0] i_hit_count,
    input logic [CNT_W-1:0] i_miss_count,
    input logic [CNT_W-1:0] i_read_count
);

    // a request keeps the block busy for at least the next cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous request still in work");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_hit_count)))
        else $error("stalled result changed");

    // hit and miss totals never go down while the result valid stays high
    a_totals_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && $past(i_rsp_valid)) |->
        ((i_hit_count >= $past(i_hit_count)) && (i_miss_count >= $past(i_miss_count))))
        else $error("running total went down");

    // every miss fetches a block, so miss and read totals move together
    a_miss_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_hit != i_memory_read) && (i_miss_count == i_read_count)))
        else $error("miss and memory read disagree");

endmodule

bind set_assoc_cache_replacement sacr_chk u_sacr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_hit         (o_rsp.hit),
    .i_memory_read (o_rsp.memory_read),
    .i_hit_count   (o_rsp.hit_count),
    .i_miss_count  (o_rsp.miss_count),
    .i_read_count  (o_rsp.read_count)
);

// ===== test/sacr_checker.sv =====
// sacr_checker: watches the request, configuration and result channels of the
// cache replacement block, predicts every result and compares it
// depends on sacr_pkg and the channel interfaces in sacr_if

module sacr_checker
    import sacr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sacr_req_if  req_mon,
    sacr_cfg_if  cfg_mon,
    sacr_rsp_if  rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W        = 48;
    localparam int STAMP_W       = 32;
    localparam int WAY_SLOTS     = 8;
    localparam int LINE_COUNT    = 2048;
    localparam int SET_LOG_CAP   = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 memory_read;
        logic                 memory_write;
        logic [CNT_W-1:0]     hit_count;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     read_count;
        logic [CNT_W-1:0]     write_count;
    } t_access_result;

    // shadow of the tag store and replacement metadata
    logic [ADDR_W-1:0]  line_tag   [LINE_COUNT];
    bit                 line_valid [LINE_COUNT];
    logic [STAMP_W-1:0] line_stamp [LINE_COUNT];
    logic [STAMP_W-1:0] access_tick;
    logic [CNT_W-1:0]   hits_total, misses_total, fetches_total, writes_total;

    // shadow of the configuration registers
    logic [POL_W-1:0]      policy;
    logic [OFF_W-1:0]      offset_log;
    logic [SETS_CFG_W-1:0] set_log;
    logic [WAYS_CFG_W-1:0] way_log;

    t_access_result expected_results[$];
    int fail_total, checked_total, hit_total;

    function automatic t_access_result predict_access(input logic cmd,
                                                      input logic [ADDR_W-1:0] addr);
        int                sb, nways, shift, base, used, free_way, w;
        logic [ADDR_W-1:0] tag, set_idx;
        bit                hit, flag_found;
        t_access_result    res;

        sb       = (set_log > SET_LOG_CAP) ? SET_LOG_CAP : int'(set_log);
        nways    = 1 << way_log;
        shift    = int'(offset_log) + sb;
        set_idx  = (addr >> offset_log) & ((ADDR_W'(1) << sb) - 1);
        tag      = addr >> shift;
        base     = int'(set_idx) * WAY_SLOTS;
        hit      = 1'b0;
        used     = 0;
        free_way = nways;

        for (w = 0; w < nways && !hit; w++) begin
            if (line_valid[base+w] && line_tag[base+w] == tag) begin
                hit  = 1'b1;
                used = w;
            end else if (!line_valid[base+w] && free_way == nways) begin
                free_way = w;
            end
        end

        if (hit) begin
            // fifo keeps the insert stamp, lru refreshes, nru clears the flag
            if (policy == POL_NRU)
                line_stamp[base+used] = '0;
            else if (policy != POL_FIFO)
                line_stamp[base+used] = access_tick;
        end else begin
            if (free_way < nways) begin
                used = free_way;
            end else if (policy == POL_NRU) begin
                flag_found = 1'b0;
                for (w = 0; w < nways && !flag_found; w++) begin
                    if (line_stamp[base+w] != '0) begin
                        used       = w;
                        flag_found = 1'b1;
                    end
                end
                if (!flag_found) begin
                    for (w = 0; w < nways; w++)
                        line_stamp[base+w] = 1;
                    used = 0;
                end
            end else begin
                // oldest stamp, lowest way on a tie
                used = 0;
                for (w = 1; w < nways; w++)
                    if (line_stamp[base+w] < line_stamp[base+used])
                        used = w;
            end
            line_valid[base+used] = 1'b1;
            line_tag[base+used]   = tag;
            line_stamp[base+used] = (policy == POL_NRU) ? '0 : access_tick;
        end

        access_tick = access_tick + 1'b1;

        if (hit) begin
            if (hits_total != '1) hits_total++;
        end else begin
            if (misses_total != '1) misses_total++;
            if (fetches_total != '1) fetches_total++;
        end
        if (cmd == CMD_WRITE && writes_total != '1)
            writes_total++;

        res.hit          = hit;
        res.way_used     = WAY_OUT_W'(used);
        res.memory_read  = !hit;
        res.memory_write = (cmd == CMD_WRITE);
        res.hit_count    = hits_total;
        res.miss_count   = misses_total;
        res.read_count   = fetches_total;
        res.write_count  = writes_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_access_result seen, want;
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_COUNT; i++) begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_stamp[i] = '0;
            end
            access_tick   = '0;
            hits_total    = '0;
            misses_total  = '0;
            fetches_total = '0;
            writes_total  = '0;
            policy        = POLICY_RESET;
            offset_log    = OFFSET_RESET;
            set_log       = SETS_RESET;
            way_log       = WAYS_RESET;
            expected_results.delete();
            fail_total    = 0;
            checked_total = 0;
            hit_total     = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (t_cfg_idx'(cfg_mon.index))
                    CFG_POLICY: policy     = cfg_mon.data[POL_W-1:0];
                    CFG_OFFSET: offset_log = cfg_mon.data[OFF_W-1:0];
                    CFG_SETS:   set_log    = cfg_mon.data[SETS_CFG_W-1:0];
                    CFG_WAYS:   way_log    = cfg_mon.data[WAYS_CFG_W-1:0];
                    default: ;
                endcase
            end

            if (rsp_mon.valid && rsp_mon.ready) begin
                seen = '{rsp_mon.hit, rsp_mon.way_used, rsp_mon.memory_read,
                         rsp_mon.memory_write, rsp_mon.hit_count, rsp_mon.miss_count,
                         rsp_mon.read_count, rsp_mon.write_count};
                if (expected_results.size() == 0) begin
                    if (fail_total < REPORT_LIMIT)
                        $display("%0t: result with no request outstanding", $realtime);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    checked_total++;
                    if (seen !== want) begin
                        if (fail_total < REPORT_LIMIT)
                            $display({"%0t: result %0d mismatch\n",
                                      "  expected hit=%0b way=%0d rd=%0b wr=%0b ",
                                      "cnt=%0d/%0d/%0d/%0d\n",
                                      "  actual   hit=%0b way=%0d rd=%0b wr=%0b ",
                                      "cnt=%0d/%0d/%0d/%0d"},
                                     $realtime, checked_total,
                                     want.hit, want.way_used, want.memory_read,
                                     want.memory_write, want.hit_count, want.miss_count,
                                     want.read_count, want.write_count,
                                     seen.hit, seen.way_used, seen.memory_read,
                                     seen.memory_write, seen.hit_count, seen.miss_count,
                                     seen.read_count, seen.write_count);
                        fail_total++;
                    end
                end
            end

            if (req_mon.valid && req_mon.ready) begin
                want = predict_access(req_mon.command, req_mon.address);
                if (want.hit) hit_total++;
                expected_results.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
        o_checked    <= checked_total;
        o_hits       <= hit_total;
    end

endmodule

// ===== test/tb_top.sv =====
// tb_top: stimulus and verdict for the set-associative cache replacement block
// depends on sacr_pkg, the channel interfaces and sacr_checker

module tb_top;
    import sacr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W           = 48;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_IDLE         = 14;
    localparam int SET_LOG_CAP      = 8;
    localparam int PHASE_COUNT      = 10;
    localparam int PHASE_ACCESSES   = 108;
    localparam int HOLD_PHASE       = 2;
    localparam logic CMD_READ       = 1'b0;
    // policy code 3 is not named by the block; it must behave as lru
    localparam logic [POL_W-1:0] POL_ALIAS_LRU = 2'd3;

    // raw register data for one phase, upper bits may be junk
    typedef struct {
        logic [CFG_DATA_W-1:0] policy;
        logic [CFG_DATA_W-1:0] offset;
        logic [CFG_DATA_W-1:0] sets;
        logic [CFG_DATA_W-1:0] ways;
    } t_geometry;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int          fail_count, pending, checked, hits;

    // current geometry as the block sees it, used to aim addresses at sets
    int cur_off = 6;
    int cur_sb  = 0;
    int cur_wb  = 0;

    int requests_sent  = 0;
    int settings_used  = 0;
    bit req_burst      = 1'b0;
    bit hold_request   = 1'b0;   // asks the result side for one long stall

    sacr_req_if #(.ADDRESS_BITS(ADDR_W)) req_if();
    sacr_cfg_if                          cfg_if();
    sacr_rsp_if                          rsp_if();

    set_assoc_cache_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    sacr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_if),
        .cfg_mon      (cfg_if),
        .rsp_mon      (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog, covers the clearing pass after reset and every stall
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request; valid stays high afterwards so back-to-back items need no
    // second assignment in the same step
    task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.address <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // stop offering requests and wait until every result is back and the
    // block has had time to settle
    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_geometry(input t_geometry g);
        write_register(CFG_POLICY, g.policy);
        write_register(CFG_OFFSET, g.offset);
        write_register(CFG_SETS,   g.sets);
        write_register(CFG_WAYS,   g.ways);
        // oversize set counts clamp to the largest supported
        cur_off = int'(g.offset[OFF_W-1:0]);
        cur_sb  = (g.sets[SETS_CFG_W-1:0] > SET_LOG_CAP) ? SET_LOG_CAP
                                                         : int'(g.sets[SETS_CFG_W-1:0]);
        cur_wb  = int'(g.ways[WAYS_CFG_W-1:0]);
        settings_used++;
    endtask

    // random accesses over a small pool of tags, so sets fill, hit and evict;
    // about one in seven addresses is pure noise over the whole address space
    task automatic run_random_phase(input int accesses, input bit keep_busy);
        logic [63:0] tag_pool [16];
        logic [63:0] tag, addr;
        int          pool_size, nsets, hot_sets, set_idx, shift;
        nsets     = 1 << cur_sb;
        hot_sets  = (nsets < 4) ? nsets : 4;
        shift     = cur_off + cur_sb;
        pool_size = (1 << cur_wb) + $urandom_range(1, 4);
        for (int i = 0; i < pool_size; i++)
            tag_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < accesses; n++) begin
            // stretches of back-to-back requests now and then; the first part
            // of the stall phase always bursts so the block backs up
            if (n % 32 == 0)
                req_burst = (keep_busy && n < 64) || ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 15) begin
                addr = {$urandom, $urandom};
            end else begin
                tag     = tag_pool[$urandom_range(0, pool_size - 1)];
                // mostly a few hot sets, sometimes any set
                set_idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nsets - 1)
                                                      : $urandom_range(0, hot_sets - 1);
                addr    = (tag << shift) | (64'(set_idx) << cur_off)
                        | ({$urandom, $urandom} & ((64'd1 << cur_off) - 1));
            end
            send_request(1'($urandom_range(0, 1)), addr[ADDR_W-1:0]);
        end
    endtask

    // result side: random ready gaps, bursts, and one long hold on request
    initial begin : result_receiver
        int gap;
        int taken;
        bit rsp_burst;
        rsp_if.ready = 1'b0;
        taken        = 0;
        rsp_burst    = 1'b0;
        wait (i_rst_n);
        forever begin
            if (taken % 32 == 0)
                rsp_burst = ($urandom_range(0, 3) == 0);
            gap = rsp_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_request) begin
                hold_request = 1'b0;
                gap          = LONG_HOLD_CYCLES;
            end
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        t_geometry plan [PHASE_COUNT];

        req_if.valid   = 1'b0;
        req_if.command = CMD_READ;
        req_if.address = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = CFG_POLICY;
        cfg_if.data    = '0;

        // settings walked by the random part, extremes first
        plan[0] = '{CFG_DATA_W'(POL_FIFO), 5'd1, 5'd0, 5'd3};       // fully associative
        plan[1] = '{CFG_DATA_W'(POL_LRU), 5'd20, 5'd8, 5'd3};       // largest geometry
        plan[2] = '{CFG_DATA_W'(POL_NRU), 5'd6, 5'd2, 5'd2};
        plan[3] = '{CFG_DATA_W'(POL_ALIAS_LRU), 5'd0, 5'd12, 5'd1}; // clamped sets
        plan[4] = '{CFG_DATA_W'(POL_FIFO), 5'd31, 5'd4, 5'd0};      // direct mapped
        plan[5] = '{CFG_DATA_W'(POL_LRU), 5'd4, 5'd1, 5'd3};
        plan[6] = '{CFG_DATA_W'(POL_NRU), 5'd12, 5'd8, 5'd3};
        plan[7] = '{CFG_DATA_W'(POL_FIFO), 5'd3, 5'd3, 5'd2};
        for (int p = 8; p < PHASE_COUNT; p++)
            plan[p] = '{5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom)};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: lru, 64-byte blocks, a single one-way set
        send_request(CMD_READ,  '0);
        send_request(CMD_WRITE, '1);
        send_request(CMD_READ,  '1);                 // same block, hit
        send_request(CMD_WRITE, '0);                 // evicts the only line
        send_request(CMD_READ,  48'h8000_0000_0000); // top address bit alone
        drain_results();

        // nru, one set of eight ways: the ninth tag finds no flag set, so the
        // whole set is flagged and way 0 goes; the next miss takes way 1
        apply_geometry('{CFG_DATA_W'(POL_NRU), 5'd1, 5'd0, 5'd3});
        for (int t = 1; t <= 10; t++)
            send_request(1'(t), ADDR_W'(t) << 1);
        send_request(CMD_READ,  ADDR_W'(3) << 1);    // hit clears its flag
        send_request(CMD_WRITE, ADDR_W'(11) << 1);
        drain_results();

        // fifo with byte-sized blocks: fresh tags replace the four ways in
        // order, and a hit must not refresh the insert stamp
        apply_geometry('{CFG_DATA_W'(POL_FIFO), 5'd0, 5'd0, 5'd2});
        for (int t = 17; t <= 20; t++)
            send_request(CMD_WRITE, ADDR_W'(t));
        send_request(CMD_READ, ADDR_W'(17));
        send_request(CMD_READ, ADDR_W'(21));         // still evicts tag 17
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            apply_geometry(plan[p]);
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            run_random_phase(PHASE_ACCESSES, p == HOLD_PHASE);
            drain_results();
        end

        $display("covered %0d requests over %0d register settings after reset defaults;",
                 requests_sent, settings_used);
        $display("%0d results compared, %0d of them hits", checked, hits);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
